FILE: hdl/bcim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcim_pkg;

   // Field widths of the registers and result items
   localparam int BLK_W      = 13;
   localparam int GRID_W     = 9;
   localparam int PROC_W     = 8;
   localparam int LROWS_W    = 21;
   localparam int LOCAL_W    = 20;
   localparam int ADDR_W     = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_BLOCK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_BLOCK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MY_PROC_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MY_PROC_COL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOCAL_ROWS  = 3'd6;

   // One result item
   typedef struct packed {
      logic [PROC_W-1:0]  owner_row;
      logic [PROC_W-1:0]  owner_col;
      logic               owned;
      logic [LOCAL_W-1:0] local_row;
      logic [LOCAL_W-1:0] local_col;
      logic [ADDR_W-1:0]  local_address;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/bcim_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per register stage.
// den must be nonzero and stay put while items are in flight.
module bcim_div_pipe #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  out_valid,
   output logic      [NUM_W-1:0] out_quot,
   output logic      [DEN_W-1:0] out_rem
);

   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] dq_ff    [NUM_W];   // dividend bits shift out, quotient bits in
   logic             valid_in [NUM_W];
   logic [DEN_W-1:0] rem_in   [NUM_W];
   logic [NUM_W-1:0] dq_in    [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] dq_prev;
      logic [DEN_W:0]   shifted;
      logic [DEN_W:0]   diff;
      logic             fits;

      if (s == 0) begin : g_first
         assign rem_prev    = '0;
         assign dq_prev     = in_num;
         assign valid_in[s] = in_valid;
      end else begin : g_next
         assign rem_prev    = rem_ff[s-1];
         assign dq_prev     = dq_ff[s-1];
         assign valid_in[s] = valid_ff[s-1];
      end

      assign shifted   = {rem_prev, dq_prev[NUM_W-1]};
      assign fits      = shifted >= {1'b0, den};
      assign diff      = shifted - {1'b0, den};
      assign rem_in[s] = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      assign dq_in[s]  = {dq_prev[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            rem_ff[s] <= rem_in[s];
            dq_ff[s]  <= dq_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = dq_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];

endmodule

`default_nettype wire

FILE: hdl/bcim_dim_map.sv
`timescale 1ns / 1ps
`default_nettype none

// One dimension: index / blk, then (index / blk) / procs.
// owner = (index / blk) mod procs, quot = index / (blk * procs), offset = index mod blk.
module bcim_dim_map #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [INDEX_BITS-1:0]         in_index,
   input  wire logic [bcim_pkg::BLK_W-1:0]    blk,
   input  wire logic [bcim_pkg::GRID_W-1:0]   procs,
   output logic                               out_valid,
   output logic      [bcim_pkg::GRID_W-1:0]   out_owner,
   output logic      [INDEX_BITS-1:0]         out_quot,
   output logic      [bcim_pkg::BLK_W-1:0]    out_offset
);

   logic                        blk_valid;
   logic [INDEX_BITS-1:0]       blk_quot;
   logic [bcim_pkg::BLK_W-1:0]  blk_rem;
   logic [bcim_pkg::BLK_W-1:0]  offset_ff [INDEX_BITS];

   bcim_div_pipe #(
      .NUM_W (INDEX_BITS),
      .DEN_W (bcim_pkg::BLK_W)
   ) u_blk_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_num    (in_index),
      .den       (blk),
      .out_valid (blk_valid),
      .out_quot  (blk_quot),
      .out_rem   (blk_rem)
   );

   bcim_div_pipe #(
      .NUM_W (INDEX_BITS),
      .DEN_W (bcim_pkg::GRID_W)
   ) u_grid_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (blk_valid),
      .in_num    (blk_quot),
      .den       (procs),
      .out_valid (out_valid),
      .out_quot  (out_quot),
      .out_rem   (out_owner)
   );

   // offset within the block rides alongside the second divider
   always_ff @(posedge clock) begin
      if (en) begin
         offset_ff[0] <= blk_rem;
         for (int s = 1; s < INDEX_BITS; s++) begin
            offset_ff[s] <= offset_ff[s-1];
         end
      end
   end

   assign out_offset = offset_ff[INDEX_BITS-1];

endmodule

`default_nettype wire

FILE: hdl/block_cyclic_index_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Block-cyclic index map: for each global (row, column) element, gives the
// owning process row and column of a 2-D block-cyclic distribution, whether
// this process owns it, the local row and column in the owner's array, and
// the column-major local address local_col * local_rows + local_row (mod
// 2^40). Takes one item per clock while req_ready is high; results return in
// order through two bit-per-stage dividers per dimension (index / block,
// then block number / grid size), then a multiply, an add, the address
// multiply and the address add. A two-entry output buffer lets the pipeline
// run while a result waits, so req_ready only drops after two results are
// held. The user must write registers only while no item is in flight,
// through csr_write/csr_index/csr_data; the block does not enforce this.
// A block or grid size written as 0 acts as 1. Owners are compared at full
// width against this process's coordinates and reported as their low 8 bits.
module block_cyclic_index_map #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               csr_write,
   input  wire logic [bcim_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcim_pkg::CSR_DATA_W-1:0]    csr_data,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [INDEX_BITS-1:0]              req_global_row,
   input  wire logic [INDEX_BITS-1:0]              req_global_col,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [bcim_pkg::PROC_W-1:0]        rsp_owner_row,
   output logic      [bcim_pkg::PROC_W-1:0]        rsp_owner_col,
   output logic                                    rsp_owned,
   output logic      [bcim_pkg::LOCAL_W-1:0]       rsp_local_row,
   output logic      [bcim_pkg::LOCAL_W-1:0]       rsp_local_col,
   output logic      [bcim_pkg::ADDR_W-1:0]        rsp_local_address
);

   localparam int BLK_W   = bcim_pkg::BLK_W;
   localparam int GRID_W  = bcim_pkg::GRID_W;
   localparam int PROC_W  = bcim_pkg::PROC_W;
   localparam int LROWS_W = bcim_pkg::LROWS_W;
   localparam int LOCAL_W = bcim_pkg::LOCAL_W;
   localparam int ADDR_W  = bcim_pkg::ADDR_W;
   localparam int PROD_W  = BLK_W + INDEX_BITS;

   // ---------------------------------------------------------------
   // Configuration registers (block and grid sizes stored as >= 1)
   // ---------------------------------------------------------------
   logic [BLK_W-1:0]   row_blk_ff;
   logic [BLK_W-1:0]   col_blk_ff;
   logic [GRID_W-1:0]  grid_rows_ff;
   logic [GRID_W-1:0]  grid_cols_ff;
   logic [PROC_W-1:0]  my_row_ff;
   logic [PROC_W-1:0]  my_col_ff;
   logic [LROWS_W-1:0] local_rows_ff;

   logic [BLK_W-1:0]   csr_blk;
   logic [GRID_W-1:0]  csr_grid;

   assign csr_blk  = (csr_data[BLK_W-1:0] == '0) ? BLK_W'(1) : csr_data[BLK_W-1:0];
   assign csr_grid = (csr_data[GRID_W-1:0] == '0) ? GRID_W'(1) : csr_data[GRID_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_blk_ff    <= BLK_W'(1);
         col_blk_ff    <= BLK_W'(1);
         grid_rows_ff  <= GRID_W'(1);
         grid_cols_ff  <= GRID_W'(1);
         my_row_ff     <= '0;
         my_col_ff     <= '0;
         local_rows_ff <= LROWS_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            bcim_pkg::REG_ROW_BLOCK:   row_blk_ff    <= csr_blk;
            bcim_pkg::REG_COL_BLOCK:   col_blk_ff    <= csr_blk;
            bcim_pkg::REG_GRID_ROWS:   grid_rows_ff  <= csr_grid;
            bcim_pkg::REG_GRID_COLS:   grid_cols_ff  <= csr_grid;
            bcim_pkg::REG_MY_PROC_ROW: my_row_ff     <= csr_data[PROC_W-1:0];
            bcim_pkg::REG_MY_PROC_COL: my_col_ff     <= csr_data[PROC_W-1:0];
            bcim_pkg::REG_LOCAL_ROWS:  local_rows_ff <= csr_data[LROWS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline advance: the whole pipe moves unless the spare output
   // slot is occupied (registered, so ready never waits on rsp_ready).
   // ---------------------------------------------------------------
   logic spare_valid_ff;
   logic adv;

   assign adv       = !spare_valid_ff;
   assign req_ready = adv;

   // ---------------------------------------------------------------
   // Dividers, one lane per dimension
   // ---------------------------------------------------------------
   logic                  row_valid;
   logic [GRID_W-1:0]     row_owner;
   logic [INDEX_BITS-1:0] row_quot;
   logic [BLK_W-1:0]      row_offset;
   logic                  col_valid;
   logic [GRID_W-1:0]     col_owner;
   logic [INDEX_BITS-1:0] col_quot;
   logic [BLK_W-1:0]      col_offset;

   bcim_dim_map #(
      .INDEX_BITS (INDEX_BITS)
   ) u_row_map (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (req_valid),
      .in_index   (req_global_row),
      .blk        (row_blk_ff),
      .procs      (grid_rows_ff),
      .out_valid  (row_valid),
      .out_owner  (row_owner),
      .out_quot   (row_quot),
      .out_offset (row_offset)
   );

   bcim_dim_map #(
      .INDEX_BITS (INDEX_BITS)
   ) u_col_map (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (req_valid),
      .in_index   (req_global_col),
      .blk        (col_blk_ff),
      .procs      (grid_cols_ff),
      .out_valid  (col_valid),
      .out_owner  (col_owner),
      .out_quot   (col_quot),
      .out_offset (col_offset)
   );

   // ---------------------------------------------------------------
   // Stage 1: block * (index / (block * grid)), low bits only; owner check
   // ---------------------------------------------------------------
   logic [PROD_W-1:0]  row_prod;
   logic [PROD_W-1:0]  col_prod;
   logic               s1_valid_ff;
   logic [LOCAL_W-1:0] s1_row_prod_ff;
   logic [LOCAL_W-1:0] s1_col_prod_ff;
   logic [BLK_W-1:0]   s1_row_off_ff;
   logic [BLK_W-1:0]   s1_col_off_ff;
   logic [PROC_W-1:0]  s1_owner_row_ff;
   logic [PROC_W-1:0]  s1_owner_col_ff;
   logic               s1_owned_ff;

   assign row_prod = PROD_W'(row_blk_ff) * PROD_W'(row_quot);
   assign col_prod = PROD_W'(col_blk_ff) * PROD_W'(col_quot);

   // ---------------------------------------------------------------
   // Stage 2: local index = product + offset within block
   // ---------------------------------------------------------------
   logic               s2_valid_ff;
   logic [LOCAL_W-1:0] s2_lrow_ff;
   logic [LOCAL_W-1:0] s2_lcol_ff;
   logic [PROC_W-1:0]  s2_owner_row_ff;
   logic [PROC_W-1:0]  s2_owner_col_ff;
   logic               s2_owned_ff;

   // ---------------------------------------------------------------
   // Stage 3: local_col * local_rows
   // ---------------------------------------------------------------
   logic               s3_valid_ff;
   logic [ADDR_W-1:0]  s3_addr_prod_ff;
   logic [LOCAL_W-1:0] s3_lrow_ff;
   logic [LOCAL_W-1:0] s3_lcol_ff;
   logic [PROC_W-1:0]  s3_owner_row_ff;
   logic [PROC_W-1:0]  s3_owner_col_ff;
   logic               s3_owned_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= row_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_row_prod_ff  <= row_prod[LOCAL_W-1:0];
         s1_col_prod_ff  <= col_prod[LOCAL_W-1:0];
         s1_row_off_ff   <= row_offset;
         s1_col_off_ff   <= col_offset;
         s1_owner_row_ff <= row_owner[PROC_W-1:0];
         s1_owner_col_ff <= col_owner[PROC_W-1:0];
         s1_owned_ff     <= (row_owner == GRID_W'(my_row_ff)) &&
                            (col_owner == GRID_W'(my_col_ff));

         s2_lrow_ff      <= s1_row_prod_ff + LOCAL_W'(s1_row_off_ff);
         s2_lcol_ff      <= s1_col_prod_ff + LOCAL_W'(s1_col_off_ff);
         s2_owner_row_ff <= s1_owner_row_ff;
         s2_owner_col_ff <= s1_owner_col_ff;
         s2_owned_ff     <= s1_owned_ff;

         s3_addr_prod_ff <= ADDR_W'(s2_lcol_ff) * ADDR_W'(local_rows_ff);
         s3_lrow_ff      <= s2_lrow_ff;
         s3_lcol_ff      <= s2_lcol_ff;
         s3_owner_row_ff <= s2_owner_row_ff;
         s3_owner_col_ff <= s2_owner_col_ff;
         s3_owned_ff     <= s2_owned_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: address add, landing in the output register or the spare
   // ---------------------------------------------------------------
   bcim_pkg::result_type s4_result;
   bcim_pkg::result_type out_ff;
   bcim_pkg::result_type spare_ff;
   logic                 out_valid_ff;
   logic                 take;
   logic                 arrive;

   always_comb begin
      s4_result.owner_row     = s3_owner_row_ff;
      s4_result.owner_col     = s3_owner_col_ff;
      s4_result.owned         = s3_owned_ff;
      s4_result.local_row     = s3_lrow_ff;
      s4_result.local_col     = s3_lcol_ff;
      s4_result.local_address = s3_addr_prod_ff + ADDR_W'(s3_lrow_ff);
   end

   assign take   = out_valid_ff && rsp_ready;
   assign arrive = adv && s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (spare_valid_ff) begin
         if (take) begin
            spare_valid_ff <= 1'b0;      // out refills from spare
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= arrive;
      end else if (arrive) begin
         spare_valid_ff <= 1'b1;         // out is held, park the new item
      end
   end

   always_ff @(posedge clock) begin
      if (spare_valid_ff) begin
         if (take) begin
            out_ff <= spare_ff;
         end
      end else if (!out_valid_ff || take) begin
         out_ff <= s4_result;
      end else begin
         spare_ff <= s4_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_owner_row     = out_ff.owner_row;
   assign rsp_owner_col     = out_ff.owner_col;
   assign rsp_owned         = out_ff.owned;
   assign rsp_local_row     = out_ff.local_row;
   assign rsp_local_col     = out_ff.local_col;
   assign rsp_local_address = out_ff.local_address;

`ifndef NO_ASSERTIONS
   // both dimension lanes stay in lockstep
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      row_valid == col_valid)
      else $error("row and column lanes out of step");

   // the spare slot is only used behind a held output
   a_spare_behind_out: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> out_valid_ff)
      else $error("spare holds an item while output is empty");

   // the spare only drains through a taken result
   a_spare_drain: assert property (@(posedge clock) disable iff (reset)
      ($fell(spare_valid_ff) && $past(!reset)) |-> $past(rsp_ready))
      else $error("spare emptied without a handoff");

   // an empty output register never blocks intake
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("intake stalled with empty output");
`endif

endmodule

`default_nettype wire

FILE: sim/block_cyclic_index_map_tb.sv
`timescale 1ns / 1ps

// Block-cyclic index map bench.
// An initial block queues coordinate items phase by phase. Between phases it
// drains the block and rewrites all seven registers. A clocked driver offers
// the queued items on the req_ channel, and a clocked receiver works the
// rsp_ready side. Every accepted item is mapped here and its result is queued.
// The monitor checks each returned item against the oldest queued result.
module block_cyclic_index_map_tb;
   import bcim_pkg::*;

   localparam int IDX_W          = 20;
   localparam int DRAIN_CYCLES   = 2 * IDX_W + 8;   // pipeline depth plus margin
   localparam int LONG_HOLD      = 300;             // receiver hold-off, cycles
   localparam int WATCHDOG_LIMIT = 4000;            // cycles with no handshake or register write
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 115;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [IDX_W-1:0] req_global_row = '0;
   logic [IDX_W-1:0] req_global_col = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PROC_W-1:0]  rsp_owner_row;
   logic [PROC_W-1:0]  rsp_owner_col;
   logic               rsp_owned;
   logic [LOCAL_W-1:0] rsp_local_row;
   logic [LOCAL_W-1:0] rsp_local_col;
   logic [ADDR_W-1:0]  rsp_local_address;

   // Bench copy of the registers, reset values
   logic [BLK_W-1:0]   cfg_row_block  = 1;
   logic [BLK_W-1:0]   cfg_col_block  = 1;
   logic [GRID_W-1:0]  cfg_grid_rows  = 1;
   logic [GRID_W-1:0]  cfg_grid_cols  = 1;
   logic [PROC_W-1:0]  cfg_my_row     = 0;
   logic [PROC_W-1:0]  cfg_my_col     = 0;
   logic [LROWS_W-1:0] cfg_local_rows = 1;

   coord_type  pending_coords[$];
   result_type predicted_maps[$];
   coord_type  next_coord;
   result_type got_map;
   result_type want_map;

   int   errors    = 0;
   logic idle_on   = 1'b1;   // random idling on both sides
   logic hold_req  = 1'b0;   // asks the receiver for one long hold-off
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   send_gap  = 0;
   int   recv_gap  = 0;
   int   quiet_cnt = 0;

   block_cyclic_index_map #(
      .INDEX_BITS(IDX_W)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_global_row   (req_global_row),
      .req_global_col   (req_global_col),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_owner_row    (rsp_owner_row),
      .rsp_owner_col    (rsp_owner_col),
      .rsp_owned        (rsp_owned),
      .rsp_local_row    (rsp_local_row),
      .rsp_local_col    (rsp_local_col),
      .rsp_local_address(rsp_local_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One dimension of the distribution: owner coordinate and local index.
   // A block or grid size of 0 counts as 1.
   function automatic void split_dim(input logic [63:0] g, input logic [63:0] blk,
                                     input logic [63:0] procs,
                                     output logic [63:0] owner, output logic [63:0] idx);
      logic [63:0] b;
      logic [63:0] p;
      b = (blk == 0) ? 64'd1 : blk;
      p = (procs == 0) ? 64'd1 : procs;
      owner = (g / b) % p;
      idx   = b * (g / (b * p)) + (g % b);
   endfunction

   // Expected result of one element under the current register copy
   function automatic result_type map_element(input logic [IDX_W-1:0] grow,
                                              input logic [IDX_W-1:0] gcol);
      result_type  r;
      logic [63:0] orow;
      logic [63:0] ocol;
      logic [63:0] lrow;
      logic [63:0] lcol;
      logic [63:0] addr;
      split_dim(64'(grow), 64'(cfg_row_block), 64'(cfg_grid_rows), orow, lrow);
      split_dim(64'(gcol), 64'(cfg_col_block), 64'(cfg_grid_cols), ocol, lcol);
      r.owner_row     = orow[PROC_W-1:0];
      r.owner_col     = ocol[PROC_W-1:0];
      // owners compared at full width, so a grid above 256 never aliases
      r.owned         = (orow == 64'(cfg_my_row)) && (ocol == 64'(cfg_my_col));
      r.local_row     = lrow[LOCAL_W-1:0];
      r.local_col     = lcol[LOCAL_W-1:0];
      addr            = 64'(r.local_col) * 64'(cfg_local_rows) + 64'(r.local_row);
      r.local_address = addr[ADDR_W-1:0];
      return r;
   endfunction

   // Driver: new item only when the bus is free or the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            predicted_maps.push_back(map_element(req_global_row, req_global_col));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_coords.size() != 0) begin
               if (idle_on && $urandom_range(0, 9) == 0) begin
                  send_gap  <= $urandom_range(1, 9) - 1;
                  req_valid <= 1'b0;
               end else begin
                  next_coord     = pending_coords.pop_front();
                  req_valid      <= 1'b1;
                  req_global_row <= next_coord.row;
                  req_global_col <= next_coord.col;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off that fills the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         recv_gap  <= $urandom_range(1, 9) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Monitor: in-order compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_map = '{rsp_owner_row, rsp_owner_col, rsp_owned, rsp_local_row,
                     rsp_local_col, rsp_local_address};
         if (predicted_maps.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual %0h", $time, got_map);
         end else begin
            want_map = predicted_maps.pop_front();
            check_field("owner_row", 64'(want_map.owner_row), 64'(got_map.owner_row));
            check_field("owner_col", 64'(want_map.owner_col), 64'(got_map.owner_col));
            check_field("owned", 64'(want_map.owned), 64'(got_map.owned));
            check_field("local_row", 64'(want_map.local_row), 64'(got_map.local_row));
            check_field("local_col", 64'(want_map.local_col), 64'(got_map.local_col));
            check_field("local_address", 64'(want_map.local_address),
                        64'(got_map.local_address));
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         quiet_cnt <= 0;
      end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
      end
   end

   task automatic queue_coord(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
      pending_coords.push_back({row, col});
   endtask

   // Sender pause: everything sent, every result back, then pipeline drain
   task automatic wait_idle();
      while (pending_coords.size() != 0 || req_valid || predicted_maps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] rb, cb, gr, gc, mr, mc, lr);
      logic [CSR_DATA_W-1:0] vals [7];
      logic [CSR_IDX_W-1:0]  idx;
      vals[REG_ROW_BLOCK]   = rb;
      vals[REG_COL_BLOCK]   = cb;
      vals[REG_GRID_ROWS]   = gr;
      vals[REG_GRID_COLS]   = gc;
      vals[REG_MY_PROC_ROW] = mr;
      vals[REG_MY_PROC_COL] = mc;
      vals[REG_LOCAL_ROWS]  = lr;
      for (int i = 0; i < 7; i++) begin
         idx = i[CSR_IDX_W-1:0];
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         // block is idle, so the copy can change right away
         case (idx)
            REG_ROW_BLOCK:   cfg_row_block  = vals[i][BLK_W-1:0];
            REG_COL_BLOCK:   cfg_col_block  = vals[i][BLK_W-1:0];
            REG_GRID_ROWS:   cfg_grid_rows  = vals[i][GRID_W-1:0];
            REG_GRID_COLS:   cfg_grid_cols  = vals[i][GRID_W-1:0];
            REG_MY_PROC_ROW: cfg_my_row     = vals[i][PROC_W-1:0];
            REG_MY_PROC_COL: cfg_my_col     = vals[i][PROC_W-1:0];
            REG_LOCAL_ROWS:  cfg_local_rows = vals[i][LROWS_W-1:0];
            default: ;
         endcase
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Block size: often small so several grid wraps fit in range; 0 and
   // the full 13-bit value show up too
   function automatic logic [CSR_DATA_W-1:0] pick_block();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 8191;
         2:       return 4096;
         5:       return CSR_DATA_W'($urandom_range(1, 4096));
         default: return CSR_DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_grid();
      case ($urandom_range(0, 6))
         0:       return 0;
         1:       return 511;
         2:       return 256;
         3:       return CSR_DATA_W'($urandom_range(1, 511));
         default: return CSR_DATA_W'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_proc(input logic [CSR_DATA_W-1:0] grid);
      int lim;
      lim = (grid == 0) ? 1 : ((grid > 256) ? 256 : int'(grid));
      // mostly a coordinate inside the grid, so owned items do come back
      if ($urandom_range(0, 9) == 0)
         return CSR_DATA_W'($urandom_range(0, 255));
      return CSR_DATA_W'($urandom_range(0, lim - 1));
   endfunction

   task automatic random_config();
      logic [CSR_DATA_W-1:0] gr;
      logic [CSR_DATA_W-1:0] gc;
      logic [CSR_DATA_W-1:0] lr;
      gr = pick_grid();
      gc = pick_grid();
      case ($urandom_range(0, 3))
         0:       lr = CSR_DATA_W'($urandom);
         1:       lr = 21'h1FFFFF;
         2:       lr = CSR_DATA_W'($urandom_range(1, 64));
         default: lr = CSR_DATA_W'($urandom_range(1, 4096));
      endcase
      set_config(pick_block(), pick_block(), gr, gc, pick_proc(gr), pick_proc(gc), lr);
   endtask

   // Half full-range coordinates, half within a few grid wraps of the origin
   task automatic run_random_phase(input int count);
      logic [63:0]      span_r;
      logic [63:0]      span_c;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      span_r = 64'((cfg_row_block == 0) ? 1 : cfg_row_block) *
               64'((cfg_grid_rows == 0) ? 1 : cfg_grid_rows) * 3;
      span_c = 64'((cfg_col_block == 0) ? 1 : cfg_col_block) *
               64'((cfg_grid_cols == 0) ? 1 : cfg_grid_cols) * 3;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 1) || span_r > 64'hFFFFF) r = IDX_W'($urandom);
         else r = IDX_W'($urandom_range(0, int'(span_r)));
         if ($urandom_range(0, 1) || span_c > 64'hFFFFF) c = IDX_W'($urandom);
         else c = IDX_W'($urandom_range(0, int'(span_c)));
         queue_coord(r, c);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values: everything maps to itself on process (0, 0)
      queue_coord(20'h00000, 20'h00000);
      queue_coord(20'hFFFFF, 20'hFFFFF);
      queue_coord(20'hFFFFF, 20'h00000);
      queue_coord(20'h00000, 20'hFFFFF);
      queue_coord(20'h00005, 20'h00003);
      queue_coord(20'hAAAAA, 20'h55555);
      wait_idle();

      // Zero block and grid sizes act as 1; zero leading dimension
      set_config(0, 0, 0, 0, 0, 0, 0);
      queue_coord(20'h00000, 20'h00000);
      queue_coord(20'h00001, 20'h00001);
      queue_coord(20'hFFFFF, 20'hFFFFF);
      queue_coord(20'h12345, 20'h6789A);
      wait_idle();

      // Grid above 256: owner 299 reads back as 43 but is not this process
      set_config(1, 8191, 300, 511, 43, 0, 21'h1FFFFF);
      queue_coord(20'd299, 20'd0);
      queue_coord(20'd43, 20'd0);
      queue_coord(20'd43, 20'd8190);
      queue_coord(20'd43, 20'd8191);
      queue_coord(20'hFFFFF, 20'hFFFFF);
      wait_idle();

      // Block of 4096, top process row, address wrap past 40 bits
      set_config(4096, 1, 256, 1, 255, 0, 21'h1FFFFF);
      queue_coord(20'hFFFFF, 20'hFFFFF);
      queue_coord(20'h00000, 20'hFFFFF);
      queue_coord(20'd4095, 20'd0);
      queue_coord(20'd4096, 20'd7);
      queue_coord(20'h7FFFF, 20'h80000);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config();
         if (p == 2)
            hold_req <= 1'b1;   // block backs up while the driver keeps offering
         if (p == RANDOM_PHASES - 1)
            idle_on <= 1'b0;    // full-rate stretch at the end
         run_random_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (errors == 0 && predicted_maps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
